// ===== rtl/nfspa_pkg.sv =====
// ============================================================================
// nfspa_pkg
// Shared codes and control bundles for the next-fit slot pool allocator.
// ============================================================================
`default_nettype none

package nfspa_pkg;

  // operation codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // fixed payload widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned GRANT_W = 4;
  localparam int unsigned COUNT_W = 5;

  // command to the busy-flag store
  typedef struct packed {
    logic wr_en;      // write wr_val at the addressed slot
    logic wr_val;
    logic clear_all;  // drop every flag
  } flags_cmd_t;

  // command to the scan walker
  typedef struct packed {
    logic load;       // restart at the search pointer
    logic step;       // move to the next slot, wrapping
  } walk_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/nfspa_if.sv =====
// ============================================================================
// nfspa_in_if / nfspa_out_if
// Valid/ready channels carrying allocator requests and results.
// ============================================================================
`default_nettype none

interface nfspa_in_if
  import nfspa_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [SLOT_W-1:0]   slot;

  modport source (output valid, output operation, output slot, input ready);
  modport sink   (input valid, input operation, input slot, output ready);
endinterface

interface nfspa_out_if
  import nfspa_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [GRANT_W-1:0]  granted_slot;
  logic [COUNT_W-1:0]  live_count;
  logic [COUNT_W-1:0]  peak_count;

  modport source (output valid, output status, output granted_slot,
                  output live_count, output peak_count, input ready);
  modport sink   (input valid, input status, input granted_slot,
                  input live_count, input peak_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/nfspa_flags.sv =====
// ============================================================================
// nfspa_flags
// Busy flag per slot, one read/write address, and a clear of all flags.
// ============================================================================
`default_nettype none

module nfspa_flags
  import nfspa_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = 16,
  parameter int unsigned IDX_W      = $clog2(POOL_SLOTS)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [IDX_W-1:0] addr,
  input  wire flags_cmd_t       cmd,
  output logic                  rd_busy
);

  logic [POOL_SLOTS-1:0] busy_r;

  assign rd_busy = busy_r[addr];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_all) begin
      busy_r <= '0;
    end else if (cmd.wr_en) begin
      busy_r[addr] <= cmd.wr_val;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nfspa_walker.sv =====
// ============================================================================
// nfspa_walker
// Scan position counter: one slot per step, wraps at the pool end.
// ============================================================================
`default_nettype none

module nfspa_walker
  import nfspa_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = 16,
  parameter int unsigned IDX_W      = $clog2(POOL_SLOTS)
) (
  input  wire logic             clk,
  input  wire walk_cmd_t        cmd,
  input  wire logic [IDX_W-1:0] start,
  output logic      [IDX_W-1:0] pos,
  output logic      [IDX_W-1:0] pos_next,  // slot after pos, wrapped
  output logic                  last       // pos is the final probe
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SLOTS - 1);

  logic [IDX_W-1:0] pos_r;
  logic [IDX_W-1:0] cnt_r;

  assign pos      = pos_r;
  assign pos_next = (pos_r == LAST_IDX) ? '0 : pos_r + 1'b1;
  assign last     = (cnt_r == LAST_IDX);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_r <= start;
      cnt_r <= '0;
    end else if (cmd.step) begin
      pos_r <= pos_next;
      cnt_r <= cnt_r + 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/next_fit_slot_pool_allocator_unit.sv =====
// ============================================================================
// next_fit_slot_pool_allocator_unit
// Next-fit allocator over a fixed pool of slots with live and peak counts.
// ============================================================================
// The unit takes one request beat at a time and answers each with exactly one
// result beat. Allocate probes one slot per cycle from the rotating search
// pointer through the walker; k (1..POOL_SLOTS) is the number of slots
// probed up to the first free one, and a full pool costs the full POOL_SLOTS
// probes. Free, pool reset and the unused code pass through the execute
// state, then the result state. The result sits in an output register, so a
// new request is taken while the previous result waits.
// Flags are cleared by block reset, so the unit is ready right after it.
// Counts are kept at full width inside and shown masked to 5 bits;
// granted_slot shows the low 4 bits of the slot index.
`default_nettype none

module next_fit_slot_pool_allocator_unit
  import nfspa_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  nfspa_in_if.sink    in_ch,
  nfspa_out_if.source out_ch
);

  localparam int unsigned IDX_W = $clog2(POOL_SLOTS);
  localparam int unsigned CNT_W = $clog2(POOL_SLOTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,   // waiting for a request
    S_EXEC,   // free / pool reset / no-op
    S_SCAN,   // allocate, one probe per cycle
    S_RESP    // hand the result to the output register
  } state_t;

  state_t              state_r,  state_nxt;
  logic [OP_W-1:0]     op_r,     op_nxt;
  logic [SLOT_W-1:0]   slot_r,   slot_nxt;
  logic [IDX_W-1:0]    ptr_r,    ptr_nxt;     // next-fit search pointer
  logic [CNT_W-1:0]    live_r,   live_nxt;
  logic [CNT_W-1:0]    peak_r,   peak_nxt;
  logic [STAT_W-1:0]   stat_r,   stat_nxt;    // pending result
  logic [IDX_W-1:0]    gidx_r,   gidx_nxt;

  logic                ovalid_r, ovalid_nxt;  // output register
  logic [STAT_W-1:0]   ostat_r,  ostat_nxt;
  logic [GRANT_W-1:0]  ogrant_r, ogrant_nxt;
  logic [COUNT_W-1:0]  olive_r,  olive_nxt;
  logic [COUNT_W-1:0]  opeak_r,  opeak_nxt;

  flags_cmd_t          fcmd;
  walk_cmd_t           wcmd;
  logic [IDX_W-1:0]    faddr;
  logic                fbusy;
  logic [IDX_W-1:0]    wpos;
  logic [IDX_W-1:0]    wpos_next;
  logic                wlast;
  logic                in_fire;
  logic                free_oor;
  logic [CNT_W-1:0]    live_inc;

  nfspa_flags #(
    .POOL_SLOTS (POOL_SLOTS),
    .IDX_W      (IDX_W)
  ) u_flags (
    .clk     (clk),
    .rst_n   (rst_n),
    .addr    (faddr),
    .cmd     (fcmd),
    .rd_busy (fbusy)
  );

  nfspa_walker #(
    .POOL_SLOTS (POOL_SLOTS),
    .IDX_W      (IDX_W)
  ) u_walker (
    .clk      (clk),
    .cmd      (wcmd),
    .start    (ptr_r),
    .pos      (wpos),
    .pos_next (wpos_next),
    .last     (wlast)
  );

  assign in_ch.ready         = (state_r == S_IDLE);
  assign in_fire             = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = ovalid_r;
  assign out_ch.status       = ostat_r;
  assign out_ch.granted_slot = ogrant_r;
  assign out_ch.live_count   = olive_r;
  assign out_ch.peak_count   = opeak_r;

  // free index beyond the pool
  assign free_oor = ({1'b0, slot_r} >= (SLOT_W + 1)'(POOL_SLOTS));
  assign live_inc = live_r + 1'b1;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    slot_nxt   = slot_r;
    ptr_nxt    = ptr_r;
    live_nxt   = live_r;
    peak_nxt   = peak_r;
    stat_nxt   = stat_r;
    gidx_nxt   = gidx_r;
    ovalid_nxt = ovalid_r;
    ostat_nxt  = ostat_r;
    ogrant_nxt = ogrant_r;
    olive_nxt  = olive_r;
    opeak_nxt  = opeak_r;
    fcmd       = '0;
    wcmd       = '0;
    faddr      = wpos;

    if (ovalid_r && out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt   = in_ch.operation;
          slot_nxt = in_ch.slot;
          if (in_ch.operation == OP_ALLOC) begin
            wcmd.load = 1'b1;
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end

      S_SCAN: begin
        faddr = wpos;
        if (!fbusy) begin
          fcmd.wr_en  = 1'b1;
          fcmd.wr_val = 1'b1;
          ptr_nxt     = wpos_next;
          live_nxt    = live_inc;
          if (live_inc > peak_r) begin
            peak_nxt = live_inc;
          end
          stat_nxt  = ST_OK;
          gidx_nxt  = wpos;
          state_nxt = S_RESP;
        end else if (wlast) begin
          stat_nxt  = ST_FULL;
          gidx_nxt  = '0;
          state_nxt = S_RESP;
        end else begin
          wcmd.step = 1'b1;
        end
      end

      S_EXEC: begin
        faddr    = slot_r[IDX_W-1:0];
        stat_nxt = ST_OK;
        gidx_nxt = '0;
        case (op_r)
          OP_FREE: begin
            if (free_oor) begin
              stat_nxt = ST_RANGE;
            end else if (fbusy) begin
              fcmd.wr_en  = 1'b1;
              fcmd.wr_val = 1'b0;
              live_nxt    = live_r - 1'b1;
            end
          end
          OP_RESET: begin
            fcmd.clear_all = 1'b1;
            ptr_nxt        = '0;
            live_nxt       = '0;
          end
          default: begin
            // unused code: report counts, touch nothing
          end
        endcase
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (!ovalid_r || out_ch.ready) begin
          ovalid_nxt = 1'b1;
          ostat_nxt  = stat_r;
          ogrant_nxt = GRANT_W'(gidx_r);
          olive_nxt  = COUNT_W'(live_r);
          opeak_nxt  = COUNT_W'(peak_r);
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ptr_r    <= '0;
      live_r   <= '0;
      peak_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ptr_r    <= ptr_nxt;
      live_r   <= live_nxt;
      peak_r   <= peak_nxt;
      ovalid_r <= ovalid_nxt;
    end
    op_r     <= op_nxt;
    slot_r   <= slot_nxt;
    stat_r   <= stat_nxt;
    gidx_r   <= gidx_nxt;
    ostat_r  <= ostat_nxt;
    ogrant_r <= ogrant_nxt;
    olive_r  <= olive_nxt;
    opeak_r  <= opeak_nxt;
  end

endmodule

`default_nettype wire

// ===== dv/next_fit_slot_pool_allocator_unit_tb.sv =====
// ============================================================================
// next_fit_slot_pool_allocator_unit_tb
// Self-checking testbench for the next-fit slot pool allocator. A local
// scoreboard model tracks busy flags, the search pointer and the live and
// peak counts, and predicts every result beat. Directed cases come first.
// Random traffic follows, with idle cycles on both sides and a long
// back-pressure stall.
// ============================================================================
`timescale 1ns / 1ps

module next_fit_slot_pool_allocator_unit_tb;
  import nfspa_pkg::*;

  localparam int unsigned SLOTS        = 16;
  localparam int unsigned QUIET_LIMIT  = 2000;  // cycles with no beat on either side
  localparam int unsigned HOLD_CYCLES  = 150;   // long receiver stall
  localparam int unsigned DRAIN_CYCLES = 40;    // settle time after the last result

  // code 3 is unused by the block; it must behave as a no-op
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [GRANT_W-1:0] grant;
    logic [COUNT_W-1:0] live;
    logic [COUNT_W-1:0] peak;
  } pool_result_t;

  logic clk;
  logic rst_n;

  nfspa_in_if  in_ch ();
  nfspa_out_if out_ch ();

  next_fit_slot_pool_allocator_unit #(
    .POOL_SLOTS(SLOTS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Scoreboard model of the pool. Updated once per accepted request beat.
  // --------------------------------------------------------------------------
  logic [SLOTS-1:0] pool_busy   = '0;
  int unsigned      next_probe  = 0;
  int unsigned      live_total  = 0;
  int unsigned      peak_total  = 0;

  pool_result_t pending_results[$];

  // run statistics
  int unsigned fault_count   = 0;
  int unsigned beats_checked = 0;
  int unsigned grant_count   = 0;
  int unsigned full_count    = 0;
  int unsigned range_count   = 0;
  int unsigned wipe_count    = 0;
  int unsigned in_stall_cyc  = 0;

  function automatic pool_result_t apply_pool_op(input logic [1:0] op,
                                                 input logic [7:0] idx);
    pool_result_t r;
    int unsigned  pos;
    bit           found;
    r        = '0;
    r.status = ST_OK;
    found    = 1'b0;
    case (op)
      OP_ALLOC: begin
        // next-fit: probe from the rotating pointer, wrap once round the pool
        for (int i = 0; i < SLOTS; i++) begin
          pos = (next_probe + i) % SLOTS;
          if (!found && !pool_busy[pos]) begin
            found          = 1'b1;
            pool_busy[pos] = 1'b1;
            live_total++;
            if (live_total > peak_total) peak_total = live_total;
            next_probe = (pos + 1) % SLOTS;
            r.grant    = pos[GRANT_W-1:0];
          end
        end
        if (found) grant_count++;
        else begin
          r.status = ST_FULL;  // pool full, state untouched
          full_count++;
        end
      end
      OP_FREE: begin
        if (idx >= SLOTS) begin
          r.status = ST_RANGE;
          range_count++;
        end else if (pool_busy[idx]) begin
          pool_busy[idx] = 1'b0;
          if (live_total > 0) live_total--;
        end
        // freeing an idle slot: ok, nothing changes
      end
      OP_RESET: begin
        // peak survives a pool reset
        pool_busy  = '0;
        next_probe = 0;
        live_total = 0;
        wipe_count++;
      end
      default: ;  // unused code: no-op, counts only
    endcase
    r.live = live_total[COUNT_W-1:0];
    r.peak = peak_total[COUNT_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      fault_count++;
      $display("[%0t] %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: predict on each request beat, check each result beat in order.
  // Both are sampled at the rising edge; the push comes first so ordering is
  // fixed inside one process.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    pool_result_t exp_r;
    pool_result_t got_r;
    if (rst_n && in_ch.valid && in_ch.ready)
      pending_results.push_back(apply_pool_op(in_ch.operation, in_ch.slot));
    if (rst_n && in_ch.valid && !in_ch.ready) in_stall_cyc++;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_r.status = out_ch.status;
      got_r.grant  = out_ch.granted_slot;
      got_r.live   = out_ch.live_count;
      got_r.peak   = out_ch.peak_count;
      if (pending_results.size() == 0) begin
        fault_count++;
        $display("[%0t] unexpected result beat: expected none, got status %0d slot %0d",
                 $time, got_r.status, got_r.grant);
      end else begin
        exp_r = pending_results.pop_front();
        beats_checked++;
        check_field("status", exp_r.status, got_r.status);
        check_field("granted_slot", exp_r.grant, got_r.grant);
        check_field("live_count", exp_r.live, got_r.live);
        check_field("peak_count", exp_r.peak, got_r.peak);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random ready, with an on-demand long hold-off counted here.
  // --------------------------------------------------------------------------
  bit          sink_idle_on = 1'b1;
  int unsigned hold_asked   = 0;
  int unsigned hold_served  = 0;
  int unsigned hold_left    = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (hold_asked != hold_served) begin
      hold_served = hold_asked;
      hold_left   = HOLD_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else if (sink_idle_on) begin
      out_ch.ready <= ($urandom_range(99) >= 17);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: a run with no beat on either channel for too long is hung.
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("[%0t] timeout: no beat for %0d cycles, %0d results outstanding",
             $time, QUIET_LIMIT, pending_results.size());
    $display("next_fit_slot_pool_allocator_unit verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sender. Called at a falling edge, returns at the falling edge after the
  // beat is taken. valid stays high between back-to-back beats; it is only
  // dropped for an idle gap.
  // --------------------------------------------------------------------------
  bit src_idle_on = 1'b1;

  task automatic send_request(input logic [1:0] op, input logic [7:0] idx);
    while (src_idle_on && $urandom_range(99) < 17) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.slot      <= idx;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // out of range frees, idle free, unused code, fill to full, wrap, pool reset
  task automatic test_directed();
    send_request(OP_FREE, 8'd255);    // top of slot field, out of range
    send_request(OP_FREE, 8'd16);     // first index past the pool
    send_request(OP_FREE, 8'd0);      // free of an idle slot
    send_request(OP_UNUSED, 8'd255);  // unused code with all slot bits set
    for (int i = 0; i < SLOTS; i++) send_request(OP_ALLOC, 8'hff);
    send_request(OP_ALLOC, 8'd0);     // pool full
    send_request(OP_FREE, 8'd15);     // last slot
    send_request(OP_FREE, 8'd5);
    send_request(OP_ALLOC, 8'd0);     // pointer wrapped to 0, first hole at 5
    send_request(OP_ALLOC, 8'd0);     // next hole is 15
    send_request(OP_RESET, 8'd0);     // counts drop, peak stays 16
    send_request(OP_ALLOC, 8'd0);     // restarts at slot 0
  endtask

  // mixed well-formed traffic with some noise
  task automatic test_random_churn(input int n_items);
    int unsigned pick;
    logic [1:0]  op;
    logic [7:0]  idx;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(99);
      idx  = 8'($urandom_range(255));
      if (pick < 48) op = OP_ALLOC;
      else if (pick < 88) begin
        op  = OP_FREE;
        idx = 8'($urandom_range(SLOTS - 1));
      end else if (pick < 93) begin
        op  = OP_FREE;
        idx = 8'($urandom_range(255, SLOTS));
      end else if (pick < 96) op = OP_RESET;
      else op = OP_UNUSED;
      send_request(op, idx);
    end
  endtask

  // fill the pool past full, then punch random holes so the scan has to walk
  task automatic test_fill_drain(input int rounds);
    for (int r = 0; r < rounds; r++) begin
      for (int i = 0; i < SLOTS + 1; i++) send_request(OP_ALLOC, 8'($urandom_range(255)));
      for (int i = 0; i < $urandom_range(14, 4); i++)
        send_request(OP_FREE, 8'($urandom_range(SLOTS - 1)));
      if ($urandom_range(7) == 0) send_request(OP_RESET, 8'($urandom_range(255)));
    end
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_back_pressure();
    hold_asked++;
    test_random_churn(40);
  endtask

  // both sides run flat out
  task automatic test_no_idle(input int n_items);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    test_random_churn(n_items);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_ALLOC;
    in_ch.slot      = '0;
    out_ch.ready    = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_churn(800);
    test_fill_drain(20);
    test_back_pressure();
    test_no_idle(450);
    test_random_churn(100);

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d results: %0d grants, %0d pool-full, %0d range errors, %0d resets",
             beats_checked, grant_count, full_count, range_count, wipe_count);
    $display("input waited %0d cycles on a busy or stalled block; peak count reached %0d",
             in_stall_cyc, peak_total);
    if (fault_count == 0) begin
      $display("next_fit_slot_pool_allocator_unit verification clean");
    end else begin
      $display("next_fit_slot_pool_allocator_unit verification failed");
    end
    $finish;
  end

endmodule
